>>> src/tmfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmfs_pkg
// Shared types and constants for the triangle mesh flip/split engine.
// ----------------------------------------------------------------------------
package tmfs_pkg;

   localparam int MaxTriangles = 1024;
   localparam int MaxPoints    = 65536;
   localparam int VertW        = 16;
   localparam int NbrW         = 11;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_FLIP   = 2'd1,
      OP_SPLIT  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_BAD    = 3'd1,
      ST_NONBR  = 3'd2,
      ST_FULL   = 3'd3,
      ST_INCONS = 3'd4
   } status_type;

endpackage

>>> src/tmfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmfs_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tmfs_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

>>> src/triangle_mesh_flip_split_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_mesh_flip_split_engine_top
// Triangle table with append, edge flip, 1-to-3 split and read operations.
// ----------------------------------------------------------------------------
// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | op, index, face, point, verts, nbrs
// rsp     | out | rsp_tvalid/rsp_tready  | status, verts, nbrs, count
// One item at a time on a single-port table memory, one access per cycle.
// Read fetches the item's entry and answers; append, flip and split write the
// table, then read back the item's entry; errors leave early, before any write.
// Reset clears the count and control; the table is not cleared.
// A stalled result holds the engine until it is taken.
// ----------------------------------------------------------------------------
module triangle_mesh_flip_split_engine_top #(
   parameter int MAX_TRIANGLES = tmfs_pkg::MaxTriangles,
   parameter int MAX_POINTS    = tmfs_pkg::MaxPoints
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[1:0], tri_index[11:2], local_face[13:12], point_index[29:14],
   // vert_a[45:30], vert_b[61:46], vert_c[77:62], nbr_a[88:78],
   // nbr_b[99:89], nbr_c[110:100], zero[111]
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], out_vert_a[18:3], out_vert_b[34:19], out_vert_c[50:35],
   // out_nbr_a[61:51], out_nbr_b[72:62], out_nbr_c[83:73], tri_count[94:84],
   // zero[95]
   output logic [95:0]  rsp_tdata
);
   localparam int AW = $clog2(MAX_TRIANGLES);
   localparam int CW = AW + 1;
   localparam int EW = 3 * tmfs_pkg::VertW + 3 * tmfs_pkg::NbrW;
   localparam int NW = tmfs_pkg::NbrW;

   typedef enum logic [13:0] {
      S_IDLE  = 14'h0001,
      S_RT    = 14'h0002,
      S_CT    = 14'h0004,
      S_RR    = 14'h0008,
      S_CR    = 14'h0010,
      S_RC    = 14'h0020,
      S_CC    = 14'h0040,
      S_RA    = 14'h0080,
      S_CA    = 14'h0100,
      S_WR    = 14'h0200,
      S_RES   = 14'h0400,
      S_RESR  = 14'h0800,
      S_OUT   = 14'h1000,
      S_RSP   = 14'h2000
   } state_type;

   // entry: v0,v1,v2 then n0,n1,n2 (low to high)
   typedef struct packed {
      logic [NW-1:0] n2, n1, n0;
      logic [15:0]   v2, v1, v0;
   } entry_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]  op_ff, op_in;
   logic [AW-1:0] ti_ff, ti_in;
   logic [1:0]  face_ff, face_in;
   logic [15:0] pt_ff, pt_in;
   entry_type   te_ff, te_in, re_ff, re_in, ne_ff, ne_in;
   logic [NW-1:0] r_ff, r_in, a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [15:0] v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in, p_ff, p_in;
   logic [1:0]  fa_ff, fa_in, fc_ff, fc_in;
   logic [2:0]  wstep_ff, wstep_in;
   logic [2:0]  st_ff, st_in;
   logic        emit_t_ff, emit_t_in;
   logic [95:0] rsp_ff, rsp_in;

   logic          we;
   logic [AW-1:0] addr;
   entry_type     wd, rd;

   tmfs_ram #(.Width(EW), .Depth(MAX_TRIANGLES)) u_table (
      .clock(clock), .wr_en(we), .addr(addr), .wr_data(wd), .rd_data(rd));

   function automatic logic [NW-1:0] nb(input entry_type e, input logic [1:0] k);
      case (k)
         2'd0:    nb = e.n0;
         2'd1:    nb = e.n1;
         default: nb = e.n2;
      endcase
   endfunction
   function automatic logic [15:0] vx(input entry_type e, input logic [1:0] k);
      case (k)
         2'd0:    vx = e.v0;
         2'd1:    vx = e.v1;
         default: vx = e.v2;
      endcase
   endfunction
   function automatic logic [1:0] inc3(input logic [1:0] k);
      inc3 = (k == 2'd2) ? 2'd0 : k + 2'd1;
   endfunction
   // face search: 3 means not found
   function automatic logic [1:0] ffind(input entry_type e, input logic [NW-1:0] tg);
      if (e.n0 == tg) ffind = 2'd0;
      else if (e.n1 == tg) ffind = 2'd1;
      else if (e.n2 == tg) ffind = 2'd2;
      else ffind = 2'd3;
   endfunction
   function automatic entry_type setnb(input entry_type e, input logic [1:0] k,
                                       input logic [NW-1:0] v);
      entry_type x;
      x = e;
      case (k)
         2'd0:    x.n0 = v;
         2'd1:    x.n1 = v;
         default: x.n2 = v;
      endcase
      setnb = x;
   endfunction

   logic [NW-1:0] tnb;
   logic [NW-1:0] rface;
   logic [NW-1:0] n_nb, n1_nb;
   logic [1:0]    j;
   logic          rvalid_ok, a_ok_idx, c_ok_idx, b_ok_idx;
   logic [CW:0]   cnt_p2;

   always_comb begin
      tnb       = NW'(ti_ff);
      rface     = nb(rd, face_ff);
      n_nb      = NW'(count_ff);
      n1_nb     = NW'(count_ff) + NW'(1);
      cnt_p2    = (CW+1)'(count_ff) + (CW+1)'(2);
      j         = ffind(rd, tnb);
      rvalid_ok = !r_ff[NW-1] && (CW'(r_ff) < count_ff);
      a_ok_idx  = CW'(a_ff) < count_ff;
      b_ok_idx  = CW'(b_ff) < count_ff;
      c_ok_idx  = CW'(c_ff) < count_ff;

      state_in  = state_ff;
      count_in  = count_ff;
      op_in = op_ff; ti_in = ti_ff; face_in = face_ff; pt_in = pt_ff;
      te_in = te_ff; re_in = re_ff; ne_in = ne_ff;
      r_in = r_ff; a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      v0_in = v0_ff; v1_in = v1_ff; v2_in = v2_ff; p_in = p_ff;
      fa_in = fa_ff; fc_in = fc_ff; wstep_in = wstep_ff;
      st_in = st_ff; emit_t_in = emit_t_ff; rsp_in = rsp_ff;
      we = 1'b0; addr = ti_ff; wd = te_ff;
      req_tready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tdata[1:0];
               ti_in   = AW'(req_tdata[11:2]);
               face_in = req_tdata[13:12];
               pt_in   = req_tdata[29:14];
               ne_in.v0 = req_tdata[45:30];
               ne_in.v1 = req_tdata[61:46];
               ne_in.v2 = req_tdata[77:62];
               ne_in.n0 = req_tdata[88:78];
               ne_in.n1 = req_tdata[99:89];
               ne_in.n2 = req_tdata[110:100];
               emit_t_in = 1'b0;
               if (req_tdata[1:0] == tmfs_pkg::OP_APPEND) begin
                  if (count_ff >= CW'(MAX_TRIANGLES)) begin
                     st_in = tmfs_pkg::ST_FULL; state_in = S_OUT;
                  end else if (32'(req_tdata[45:30]) >= MAX_POINTS ||
                               32'(req_tdata[61:46]) >= MAX_POINTS ||
                               32'(req_tdata[77:62]) >= MAX_POINTS) begin
                     st_in = tmfs_pkg::ST_BAD; state_in = S_OUT;
                  end else begin
                     st_in = tmfs_pkg::ST_OK;
                     ti_in = AW'(count_ff); wstep_in = 3'd7; state_in = S_WR;
                  end
               end else if (CW'(req_tdata[11:2]) >= count_ff ||
                            32'(req_tdata[11:2]) >= MAX_TRIANGLES) begin
                  st_in = tmfs_pkg::ST_BAD; state_in = S_OUT;
               end else if (req_tdata[1:0] == tmfs_pkg::OP_FLIP &&
                            req_tdata[13:12] == 2'd3) begin
                  st_in = tmfs_pkg::ST_BAD; state_in = S_OUT;
               end else if (req_tdata[1:0] == tmfs_pkg::OP_SPLIT &&
                            32'(req_tdata[29:14]) >= MAX_POINTS) begin
                  st_in = tmfs_pkg::ST_BAD; state_in = S_OUT;
               end else begin
                  st_in = tmfs_pkg::ST_OK; state_in = S_RT;
               end
            end
         end
         S_RT: begin
            addr = ti_ff; state_in = S_CT;
         end
         S_CT: begin
            te_in = rd; emit_t_in = 1'b1;
            if (op_ff == tmfs_pkg::OP_READ) begin
               state_in = S_OUT;
            end else if (op_ff == tmfs_pkg::OP_FLIP) begin
               v0_in = vx(rd, face_ff);
               v1_in = vx(rd, inc3(face_ff));
               v2_in = vx(rd, inc3(inc3(face_ff)));
               r_in  = rface;
               a_in  = nb(rd, inc3(face_ff));
               b_in  = nb(rd, inc3(inc3(face_ff)));
               if (rface[NW-1]) begin
                  st_in = tmfs_pkg::ST_NONBR; state_in = S_OUT;
               end else begin
                  state_in = S_RR;
               end
            end else begin
               a_in = rd.n0; b_in = rd.n1; c_in = rd.n2;
               if (cnt_p2 > (CW+1)'(MAX_TRIANGLES)) begin
                  st_in = tmfs_pkg::ST_FULL; state_in = S_OUT;
               end else if (rd.n1 == tnb || rd.n2 == tnb ||
                            (!rd.n1[NW-1] && rd.n1 == rd.n2)) begin
                  st_in = tmfs_pkg::ST_INCONS; state_in = S_OUT;
               end else begin
                  state_in = S_RC;
               end
            end
         end
         S_RR: begin
            if (!rvalid_ok || r_ff == tnb) begin
               st_in = tmfs_pkg::ST_INCONS; state_in = S_OUT;
            end else begin
               addr = AW'(r_ff); state_in = S_CR;
            end
         end
         S_CR: begin
            re_in = rd;
            if (j == 2'd3) begin
               st_in = tmfs_pkg::ST_INCONS; state_in = S_OUT;
            end else begin
               p_in = vx(rd, inc3(inc3(j)));
               c_in = nb(rd, inc3(j));
               d_in = nb(rd, inc3(inc3(j)));
               if (a_ff == tnb || a_ff == r_ff || nb(rd, inc3(j)) == tnb ||
                   nb(rd, inc3(j)) == r_ff) begin
                  st_in = tmfs_pkg::ST_INCONS; state_in = S_OUT;
               end else begin
                  state_in = S_RC;
               end
            end
         end
         // flip: C then A; split: B (in b_ff) then C
         S_RC: begin
            if (op_ff == tmfs_pkg::OP_FLIP ? c_ff[NW-1] : b_ff[NW-1]) begin
               fc_in = 2'd3; state_in = S_RA;
            end else if (op_ff == tmfs_pkg::OP_FLIP ? !c_ok_idx : !b_ok_idx) begin
               st_in = tmfs_pkg::ST_INCONS; state_in = S_OUT;
            end else begin
               addr = AW'(op_ff == tmfs_pkg::OP_FLIP ? c_ff : b_ff); state_in = S_CC;
            end
         end
         S_CC: begin
            fc_in = ffind(rd, op_ff == tmfs_pkg::OP_FLIP ? r_ff : tnb);
            if (ffind(rd, op_ff == tmfs_pkg::OP_FLIP ? r_ff : tnb) == 2'd3) begin
               st_in = tmfs_pkg::ST_INCONS; state_in = S_OUT;
            end else begin
               re_in = rd; state_in = S_RA;
            end
         end
         S_RA: begin
            if (op_ff == tmfs_pkg::OP_FLIP ? a_ff[NW-1] : c_ff[NW-1]) begin
               fa_in = 2'd3; wstep_in = 3'd0; state_in = S_WR;
            end else if (op_ff == tmfs_pkg::OP_FLIP ? !a_ok_idx : !c_ok_idx) begin
               st_in = tmfs_pkg::ST_INCONS; state_in = S_OUT;
            end else begin
               addr = AW'(op_ff == tmfs_pkg::OP_FLIP ? a_ff : c_ff); state_in = S_CA;
            end
         end
         S_CA: begin
            fa_in = ffind(rd, tnb);
            if (ffind(rd, tnb) == 2'd3) begin
               st_in = tmfs_pkg::ST_INCONS; state_in = S_OUT;
            end else begin
               // hold A entry (flip) or C entry (split) in ne (append payload not needed here)
               ne_in = rd; wstep_in = 3'd0; state_in = S_WR;
            end
         end
         S_WR: begin
            we = 1'b1;
            wstep_in = wstep_ff + 3'd1;
            if (wstep_ff == 3'd7) begin
               addr = ti_ff; wd = ne_ff; count_in = count_ff + CW'(1);
               emit_t_in = 1'b0; state_in = S_RES;
            end else if (op_ff == tmfs_pkg::OP_FLIP) begin
               case (wstep_ff)
                  3'd0: begin
                     addr = ti_ff;
                     wd = '{n2: c_ff, n1: b_ff, n0: r_ff, v2: v0_ff, v1: v2_ff, v0: p_ff};
                  end
                  3'd1: begin
                     addr = AW'(r_ff);
                     wd = '{n2: tnb, n1: a_ff, n0: d_ff, v2: v2_ff, v1: v1_ff, v0: p_ff};
                  end
                  3'd2: begin
                     addr = AW'(c_ff); wd = setnb(re_ff, fc_ff, tnb);
                     we = !c_ff[NW-1];
                  end
                  default: begin
                     // A may be the same entry as C: keep both updates
                     addr = AW'(a_ff);
                     wd = setnb((a_ff == c_ff) ? setnb(ne_ff, fc_ff, tnb) : ne_ff,
                                fa_ff, r_ff);
                     we = !a_ff[NW-1]; state_in = S_RES;
                  end
               endcase
            end else begin
               case (wstep_ff)
                  3'd0: begin
                     addr = ti_ff;
                     wd = '{n2: n_nb, n1: te_ff.n0, n0: n1_nb,
                            v2: te_ff.v1, v1: te_ff.v0, v0: pt_ff};
                  end
                  3'd1: begin
                     addr = AW'(count_ff);
                     wd = '{n2: n1_nb, n1: b_ff, n0: tnb,
                            v2: te_ff.v2, v1: te_ff.v1, v0: pt_ff};
                  end
                  3'd2: begin
                     addr = AW'(count_ff + CW'(1));
                     wd = '{n2: tnb, n1: c_ff, n0: n_nb,
                            v2: te_ff.v0, v1: te_ff.v2, v0: pt_ff};
                  end
                  3'd3: begin
                     addr = AW'(b_ff); wd = setnb(re_ff, fc_ff, n_nb);
                     we = !b_ff[NW-1];
                  end
                  default: begin
                     addr = AW'(c_ff); wd = setnb(ne_ff, fa_ff, n1_nb);
                     we = !c_ff[NW-1]; count_in = count_ff + CW'(2);
                     state_in = S_RES;
                  end
               endcase
            end
         end
         S_RES: begin
            addr = ti_ff; state_in = S_RESR;
         end
         S_RESR: begin
            te_in = rd; emit_t_in = 1'b1; state_in = S_OUT;
         end
         S_OUT: begin
            rsp_in[2:0] = st_ff;
            if (emit_t_ff) begin
               rsp_in[50:3]  = {te_ff.v2, te_ff.v1, te_ff.v0};
               rsp_in[83:51] = {te_ff.n2, te_ff.n1, te_ff.n0};
            end else begin
               rsp_in[50:3]  = '0;
               rsp_in[83:51] = '1;
            end
            rsp_in[94:84] = 11'(count_ff);
            rsp_in[95]    = 1'b0;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = (state_ff == S_RSP);
   assign rsp_tdata  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff <= op_in; ti_ff <= ti_in; face_ff <= face_in; pt_ff <= pt_in;
      te_ff <= te_in; re_ff <= re_in; ne_ff <= ne_in;
      r_ff <= r_in; a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      v0_ff <= v0_in; v1_ff <= v1_in; v2_ff <= v2_in; p_ff <= p_in;
      fa_ff <= fa_in; fc_ff <= fc_in; wstep_ff <= wstep_in;
      st_ff <= st_in; emit_t_ff <= emit_t_in; rsp_ff <= rsp_in;
   end
endmodule

>>> tb/sv/triangle_mesh_flip_split_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_mesh_flip_split_engine_top_tb
// Self-checking bench for the triangle mesh flip/split engine. A local mesh
// model predicts status, entry and count for every accepted request item.
// Directed tests cover append/read extremes, flips, splits, every error
// status and a full table. A random phase grows a consistent mesh by splits
// and flips and mixes in noise. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module triangle_mesh_flip_split_engine_top_tb;

   typedef struct {
      tmfs_pkg::status_type st;
      logic [15:0]      v [3];
      logic signed [10:0] n [3];
      logic [10:0]      cnt;
   } mesh_rsp_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [95:0]  rsp_tdata;

   logic [15:0]  vtab [tmfs_pkg::MaxTriangles][3];
   int           ntab [tmfs_pkg::MaxTriangles][3];
   int           tri_total = 0;
   mesh_rsp_type pending_rsp [$];
   int           errors = 0;
   bit           idle_en = 1;
   int           hold_cycles = 0;
   int           stall_left = 0;
   int           quiet_cycles = 0;

   triangle_mesh_flip_split_engine_top dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic mesh_rsp_type entry_rsp(tmfs_pkg::status_type st, int t);
      mesh_rsp_type r;
      r.st = st;
      for (int k = 0; k < 3; k++) begin
         r.v[k] = (t >= 0) ? vtab[t][k] : 16'd0;
         r.n[k] = (t >= 0) ? ntab[t][k][10:0] : -11'sd1;
      end
      r.cnt = tri_total[10:0];
      return r;
   endfunction

   function automatic bit tri_ok(int t);
      return t >= 0 && t < tri_total;
   endfunction

   function automatic int find_face(int t, int target);
      for (int k = 0; k < 3; k++)
         if (ntab[t][k] == target) return k;
      return -1;
   endfunction

   function automatic mesh_rsp_type flip_edge(int t, int i);
      logic [15:0] v0, v1, v2, p;
      int r, a, b, c, d, j, fc, fa;
      v0 = vtab[t][i];
      v1 = vtab[t][(i + 1) % 3];
      v2 = vtab[t][(i + 2) % 3];
      r = ntab[t][i];
      a = ntab[t][(i + 1) % 3];
      b = ntab[t][(i + 2) % 3];
      fc = -1;
      fa = -1;
      if (r < 0) return entry_rsp(tmfs_pkg::ST_NONBR, t);
      if (!tri_ok(r) || r == t) return entry_rsp(tmfs_pkg::ST_INCONS, t);
      j = find_face(r, t);
      if (j < 0) return entry_rsp(tmfs_pkg::ST_INCONS, t);
      p = vtab[r][(j + 2) % 3];
      c = ntab[r][(j + 1) % 3];
      d = ntab[r][(j + 2) % 3];
      if (a == t || a == r || c == t || c == r) return entry_rsp(tmfs_pkg::ST_INCONS, t);
      if (c >= 0) begin
         if (!tri_ok(c)) return entry_rsp(tmfs_pkg::ST_INCONS, t);
         fc = find_face(c, r);
         if (fc < 0) return entry_rsp(tmfs_pkg::ST_INCONS, t);
      end
      if (a >= 0) begin
         if (!tri_ok(a)) return entry_rsp(tmfs_pkg::ST_INCONS, t);
         fa = find_face(a, t);
         if (fa < 0) return entry_rsp(tmfs_pkg::ST_INCONS, t);
      end
      vtab[t][0] = p; vtab[t][1] = v2; vtab[t][2] = v0;
      ntab[t][0] = r; ntab[t][1] = b; ntab[t][2] = c;
      vtab[r][0] = p; vtab[r][1] = v1; vtab[r][2] = v2;
      ntab[r][0] = d; ntab[r][1] = a; ntab[r][2] = t;
      if (c >= 0) ntab[c][fc] = t;
      if (a >= 0) ntab[a][fa] = r;
      return entry_rsp(tmfs_pkg::ST_OK, t);
   endfunction

   function automatic mesh_rsp_type split_tri(int t, logic [15:0] p);
      logic [15:0] v1, v2, v3;
      int a, b, c, n, fb, fc;
      v1 = vtab[t][0]; v2 = vtab[t][1]; v3 = vtab[t][2];
      a = ntab[t][0]; b = ntab[t][1]; c = ntab[t][2];
      n = tri_total;
      fb = -1;
      fc = -1;
      if (tri_total + 2 > tmfs_pkg::MaxTriangles) return entry_rsp(tmfs_pkg::ST_FULL, t);
      if (b == t || c == t || (b >= 0 && b == c)) return entry_rsp(tmfs_pkg::ST_INCONS, t);
      if (b >= 0) begin
         if (!tri_ok(b)) return entry_rsp(tmfs_pkg::ST_INCONS, t);
         fb = find_face(b, t);
         if (fb < 0) return entry_rsp(tmfs_pkg::ST_INCONS, t);
      end
      if (c >= 0) begin
         if (!tri_ok(c)) return entry_rsp(tmfs_pkg::ST_INCONS, t);
         fc = find_face(c, t);
         if (fc < 0) return entry_rsp(tmfs_pkg::ST_INCONS, t);
      end
      vtab[t][0] = p; vtab[t][1] = v1; vtab[t][2] = v2;
      ntab[t][0] = n + 1; ntab[t][1] = a; ntab[t][2] = n;
      vtab[n][0] = p; vtab[n][1] = v2; vtab[n][2] = v3;
      ntab[n][0] = t; ntab[n][1] = b; ntab[n][2] = n + 1;
      vtab[n + 1][0] = p; vtab[n + 1][1] = v3; vtab[n + 1][2] = v1;
      ntab[n + 1][0] = n; ntab[n + 1][1] = c; ntab[n + 1][2] = t;
      if (b >= 0) ntab[b][fb] = n;
      if (c >= 0) ntab[c][fc] = n + 1;
      tri_total += 2;
      return entry_rsp(tmfs_pkg::ST_OK, t);
   endfunction

   function automatic mesh_rsp_type mesh_apply(logic [111:0] d);
      tmfs_pkg::op_type op;
      int ti, face, n;
      op = tmfs_pkg::op_type'(d[1:0]);
      ti = int'(d[11:2]);
      face = int'(d[13:12]);
      if (op == tmfs_pkg::OP_APPEND) begin
         n = tri_total;
         if (n >= tmfs_pkg::MaxTriangles) return entry_rsp(tmfs_pkg::ST_FULL, -1);
         for (int k = 0; k < 3; k++) begin
            vtab[n][k] = d[30 + 16 * k +: 16];
            ntab[n][k] = $signed(d[78 + 11 * k +: 11]);
         end
         tri_total = n + 1;
         return entry_rsp(tmfs_pkg::ST_OK, n);
      end
      if (ti >= tri_total) return entry_rsp(tmfs_pkg::ST_BAD, -1);
      if (op == tmfs_pkg::OP_READ) return entry_rsp(tmfs_pkg::ST_OK, ti);
      if (op == tmfs_pkg::OP_FLIP) begin
         if (face > 2) return entry_rsp(tmfs_pkg::ST_BAD, -1);
         return flip_edge(ti, face);
      end
      return split_tri(ti, d[29:14]);
   endfunction

   function automatic logic [111:0] pack_req(tmfs_pkg::op_type op, int ti, int face,
                                             int pt, int va, int vb, int vc,
                                             int na, int nb, int nc);
      return {1'b0, nc[10:0], nb[10:0], na[10:0], vc[15:0], vb[15:0], va[15:0],
              pt[15:0], face[1:0], ti[9:0], op};
   endfunction

   task automatic send_item(logic [111:0] d);
      if (idle_en && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(mesh_apply(d));
      @(negedge clock);
   endtask

   task automatic send_op(tmfs_pkg::op_type op, int ti, int face = 0, int pt = 0);
      send_item(pack_req(op, ti, face, pt, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic send_append(int va, int vb, int vc, int na, int nb, int nc);
      send_item(pack_req(tmfs_pkg::OP_APPEND, 0, 0, 0, va, vb, vc, na, nb, nc));
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 0;
         hold_cycles--;
      end else if (stall_left > 0) begin
         rsp_tready <= 0;
         stall_left--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 0;
         stall_left = $urandom_range(1, 18) - 1;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      mesh_rsp_type e;
      logic [95:0] got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result item %h", $time, got);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (got[2:0] !== e.st) begin
               $display("%0t: status exp %0d got %0d", $time, e.st, got[2:0]);
               errors++;
            end
            for (int k = 0; k < 3; k++) begin
               if (got[3 + 16 * k +: 16] !== e.v[k]) begin
                  $display("%0t: vert %0d exp %h got %h", $time, k, e.v[k],
                           got[3 + 16 * k +: 16]);
                  errors++;
               end
               if (got[51 + 11 * k +: 11] !== e.n[k]) begin
                  $display("%0t: nbr %0d exp %0d got %0d", $time, k, e.n[k],
                           $signed(got[51 + 11 * k +: 11]));
                  errors++;
               end
            end
            if (got[94:84] !== e.cnt) begin
               $display("%0t: count exp %0d got %0d", $time, e.cnt, got[94:84]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= 5000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic test_append_read();
      send_append(16'hFFFF, 16'h0000, 16'hAAAA, 1023, -1, -1024);
      send_append(16'h5555, 16'h0001, 16'h8000, 11'h3FF, 11'h000, 11'h7FF);
      send_op(tmfs_pkg::OP_READ, 0);
      send_op(tmfs_pkg::OP_READ, tri_total - 1);
   endtask

   task automatic test_flip();
      int t0;
      t0 = tri_total;
      send_append(10, 11, 12, t0 + 1, -1, -1);
      send_append(11, 10, 13, t0, -1, -1);
      send_op(tmfs_pkg::OP_FLIP, t0, 0);
      send_op(tmfs_pkg::OP_FLIP, t0, 0);
      send_op(tmfs_pkg::OP_READ, t0 + 1);
      send_op(tmfs_pkg::OP_FLIP, t0, 1);
   endtask

   task automatic test_split();
      send_op(tmfs_pkg::OP_SPLIT, tri_total - 1, 0, 16'hFFFF);
      send_op(tmfs_pkg::OP_SPLIT, 0, 0, 16'h0000);
      send_op(tmfs_pkg::OP_READ, tri_total - 1);
   endtask

   task automatic test_errors();
      int t;
      send_op(tmfs_pkg::OP_READ, 1023);
      send_op(tmfs_pkg::OP_FLIP, 1023, 0);
      send_op(tmfs_pkg::OP_SPLIT, 1023, 0, 7);
      send_op(tmfs_pkg::OP_FLIP, 0, 3);
      t = tri_total;
      send_append(1, 2, 3, 1023, t, t);
      send_op(tmfs_pkg::OP_FLIP, t, 0);
      send_op(tmfs_pkg::OP_SPLIT, t, 0, 9);
      send_append(1, 2, 3, t, -1, -1);
      send_op(tmfs_pkg::OP_FLIP, t + 1, 0);
      send_append(4, 5, 6, -1, 0, 0);
      send_op(tmfs_pkg::OP_SPLIT, t + 2, 0, 3);
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_cycles = 300;
      for (int k = 0; k < 12; k++)
         send_op(tmfs_pkg::OP_READ, $urandom_range(0, tri_total - 1));
   endtask

   task automatic test_random(int count);
      int r;
      logic [111:0] d;
      send_append($urandom, $urandom, $urandom, -1, -1, -1);
      for (int k = 0; k < count; k++) begin
         if (k == count - 100) idle_en = 0;
         r = $urandom_range(0, 99);
         d = 112'({$urandom, $urandom, $urandom, $urandom});
         d[111] = 0;
         if (r < 40) begin
            d[1:0] = tmfs_pkg::OP_FLIP;
            d[11:2] = 10'($urandom_range(0, tri_total - 1));
            d[13:12] = 2'(($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2));
         end else if (r < 60 && tri_total < 900) begin
            d[1:0] = tmfs_pkg::OP_SPLIT;
            d[11:2] = 10'($urandom_range(0, tri_total - 1));
         end else if (r < 75) begin
            d[1:0] = tmfs_pkg::OP_READ;
            d[11:2] = 10'($urandom_range(0, tri_total - 1));
         end else if (r < 85) begin
            d[1:0] = tmfs_pkg::OP_APPEND;
            d[110:78] = '1;
         end else if (r < 92) begin
            d[1:0] = tmfs_pkg::OP_APPEND;
         end else begin
            d[11:2] = 10'($urandom_range(tri_total, 1023));
         end
         send_item(d);
      end
   endtask

   task automatic test_table_full();
      int prev_total;
      idle_en = 0;
      send_append($urandom, $urandom, $urandom, -1, -1, -1);
      while (tri_total < tmfs_pkg::MaxTriangles - 1) begin
         prev_total = tri_total;
         if (tri_total + 2 <= tmfs_pkg::MaxTriangles - 1)
            send_op(tmfs_pkg::OP_SPLIT, tri_total - 1, 0, $urandom_range(0, 65535));
         if (tri_total == prev_total)
            send_append($urandom, $urandom, $urandom, -1, -1, -1);
      end
      send_op(tmfs_pkg::OP_SPLIT, 0, 0, 5);
      send_append(7, 8, 9, -1, -1, -1);
      send_append(7, 8, 9, -1, -1, -1);
      send_op(tmfs_pkg::OP_SPLIT, 1, 0, 5);
      send_op(tmfs_pkg::OP_READ, tmfs_pkg::MaxTriangles - 1);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_append_read();
      test_flip();
      test_split();
      test_errors();
      test_backpressure();
      test_random(400);
      test_table_full();
      wait_drained();
      repeat (40) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
